[src/vml_pkg.sv]
package vml_pkg;

   // Limit register value after reset, truncated to the data width at use
   localparam int unsigned MAG_RESET = 32767;

   // Register stages ahead of the square root: absolute value, squares, sum
   localparam int unsigned PRE_STAGES = 3;

   // Register stage between root and divider: compare and scale products
   localparam int unsigned MID_STAGES = 1;

   // Output register stage: sign restore and select
   localparam int unsigned POST_STAGES = 1;

   // Side data of one vector on its way through the divider
   typedef struct packed {
      logic        neg_x;
      logic        neg_y;
   } sign_type;

endpackage

[src/vector_magnitude_limiter.sv]
// Channel   Ports                                          Direction  Handshake
// request   start, busy, req_x_in, req_y_in                in         start && !busy
// response  rsp_valid, rsp_x_out, rsp_y_out,               out        rsp_valid, one cycle
//           rsp_was_limited
// csr       csr_valid, csr_ready, csr_max_magnitude        in         csr_valid && csr_ready
//
// One request per cycle. The square root and the two-lane divider each resolve
// one result bit per pipeline stage.
// Reset clears all valid bits and loads the limit with 32767 (truncated to width).
// The receiver cannot stall, so busy and the pipeline never hold; csr_ready stays high.
module vector_magnitude_limiter
   import vml_pkg::*;
#(
   parameter int unsigned DATA_WIDTH = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic signed [DATA_WIDTH-1:0] req_x_in,
   input  logic signed [DATA_WIDTH-1:0] req_y_in,
   output logic                         rsp_valid,
   output logic signed [DATA_WIDTH-1:0] rsp_x_out,
   output logic signed [DATA_WIDTH-1:0] rsp_y_out,
   output logic                         rsp_was_limited,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic        [DATA_WIDTH-1:0] csr_max_magnitude
);

   localparam int unsigned PROD_W  = 2 * DATA_WIDTH;
   localparam int unsigned STAG_W  = 4 * DATA_WIDTH;
   localparam int unsigned DTAG_W  = 2 * DATA_WIDTH + 3;
   localparam int unsigned LATENCY = PRE_STAGES + DATA_WIDTH + MID_STAGES + DATA_WIDTH
                                     + POST_STAGES;
   localparam logic [DATA_WIDTH-1:0] LIM_RESET = DATA_WIDTH'(MAG_RESET);

   logic accept;

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;
   assign accept    = start && !busy;

   // Limit register
   logic [DATA_WIDTH-1:0] lim_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         lim_ff <= LIM_RESET;
      end else if (csr_valid && csr_ready) begin
         lim_ff <= csr_max_magnitude;
      end
   end

   // Stage 1: capture request and take absolute values
   logic                  s1_valid_ff;
   logic [DATA_WIDTH-1:0] s1_x_ff, s1_y_ff, s1_ax_ff, s1_ay_ff;
   logic [DATA_WIDTH-1:0] s1_x_in, s1_y_in, s1_ax_in, s1_ay_in;

   assign s1_x_in  = $unsigned(req_x_in);
   assign s1_y_in  = $unsigned(req_y_in);
   assign s1_ax_in = s1_x_in[DATA_WIDTH-1] ? (~s1_x_in + 1'b1) : s1_x_in;
   assign s1_ay_in = s1_y_in[DATA_WIDTH-1] ? (~s1_y_in + 1'b1) : s1_y_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      s1_x_ff  <= s1_x_in;
      s1_y_ff  <= s1_y_in;
      s1_ax_ff <= s1_ax_in;
      s1_ay_ff <= s1_ay_in;
   end

   // Stage 2: square each component
   logic                  s2_valid_ff;
   logic [DATA_WIDTH-1:0] s2_x_ff, s2_y_ff, s2_ax_ff, s2_ay_ff;
   logic [PROD_W-1:0]     s2_sqx_ff, s2_sqy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s2_x_ff   <= s1_x_ff;
      s2_y_ff   <= s1_y_ff;
      s2_ax_ff  <= s1_ax_ff;
      s2_ay_ff  <= s1_ay_ff;
      s2_sqx_ff <= PROD_W'(s1_ax_ff) * PROD_W'(s1_ax_ff);
      s2_sqy_ff <= PROD_W'(s1_ay_ff) * PROD_W'(s1_ay_ff);
   end

   // Stage 3: sum of squares; it is at most 2^(2*DATA_WIDTH-1)
   logic                  s3_valid_ff;
   logic [STAG_W-1:0]     s3_tag_ff;
   logic [PROD_W-1:0]     s3_sum_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else begin
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s3_tag_ff <= {s2_x_ff, s2_y_ff, s2_ax_ff, s2_ay_ff};
      s3_sum_ff <= s2_sqx_ff + s2_sqy_ff;
   end

   // Floor square root, one bit per stage
   logic                  rt_valid;
   logic [DATA_WIDTH-1:0] rt_root;
   logic [STAG_W-1:0]     rt_tag;

   vml_isqrt #(
      .RES_WIDTH (DATA_WIDTH),
      .TAG_WIDTH (STAG_W)
   ) u_isqrt (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (s3_valid_ff),
      .in_radicand (s3_sum_ff),
      .in_tag      (s3_tag_ff),
      .out_valid   (rt_valid),
      .out_root    (rt_root),
      .out_tag     (rt_tag)
   );

   // Mid stage: compare against the limit and form component * limit
   logic [DATA_WIDTH-1:0] rt_x, rt_y, rt_ax, rt_ay;
   sign_type              rt_sign;
   logic                  md_valid_ff;
   logic                  md_limited_ff;
   sign_type              md_sign_ff;
   logic [DATA_WIDTH-1:0] md_x_ff, md_y_ff, md_root_ff;
   logic [PROD_W-1:0]     md_px_ff, md_py_ff;

   assign {rt_x, rt_y, rt_ax, rt_ay} = rt_tag;
   assign rt_sign.neg_x = rt_x[DATA_WIDTH-1];
   assign rt_sign.neg_y = rt_y[DATA_WIDTH-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         md_valid_ff <= 1'b0;
      end else begin
         md_valid_ff <= rt_valid;
      end
   end

   always_ff @(posedge clock) begin
      md_limited_ff <= (rt_root > lim_ff);
      md_sign_ff    <= rt_sign;
      md_x_ff       <= rt_x;
      md_y_ff       <= rt_y;
      md_root_ff    <= rt_root;
      md_px_ff      <= PROD_W'(rt_ax) * PROD_W'(lim_ff);
      md_py_ff      <= PROD_W'(rt_ay) * PROD_W'(lim_ff);
   end

   // Divide both scaled components by the magnitude
   logic                  dv_valid;
   logic [DATA_WIDTH-1:0] dv_qx, dv_qy;
   logic [DTAG_W-1:0]     dv_tag;

   vml_div #(
      .QUO_WIDTH (DATA_WIDTH),
      .TAG_WIDTH (DTAG_W)
   ) u_div (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (md_valid_ff),
      .in_dividend_a (md_px_ff),
      .in_dividend_b (md_py_ff),
      .in_divisor    (md_root_ff),
      .in_tag        ({md_x_ff, md_y_ff, md_limited_ff, md_sign_ff}),
      .out_valid     (dv_valid),
      .out_quot_a    (dv_qx),
      .out_quot_b    (dv_qy),
      .out_tag       (dv_tag)
   );

   // Output stage: restore signs of the quotients or pass the request through
   logic [DATA_WIDTH-1:0] dv_x, dv_y;
   logic                  dv_limited;
   sign_type              dv_sign;
   logic                  out_valid_ff, out_limited_ff;
   logic [DATA_WIDTH-1:0] out_x_ff, out_y_ff, out_x_in, out_y_in;
   logic [DATA_WIDTH-1:0] sx, sy;

   assign {dv_x, dv_y, dv_limited, dv_sign} = dv_tag;
   assign sx       = dv_sign.neg_x ? (~dv_qx + 1'b1) : dv_qx;
   assign sy       = dv_sign.neg_y ? (~dv_qy + 1'b1) : dv_qy;
   assign out_x_in = dv_limited ? sx : dv_x;
   assign out_y_in = dv_limited ? sy : dv_y;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= dv_valid;
      end
   end

   always_ff @(posedge clock) begin
      out_x_ff       <= out_x_in;
      out_y_ff       <= out_y_in;
      out_limited_ff <= dv_limited;
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_x_out       = $signed(out_x_ff);
   assign rsp_y_out       = $signed(out_y_ff);
   assign rsp_was_limited = out_limited_ff;

`ifndef NO_ASSERTIONS
   // A response only follows a request taken the pipeline latency earlier
   a_rsp_has_request: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start, LATENCY))
      else $error("response without matching request");

   // An unlimited response equals its request
   a_pass_through: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_was_limited) |->
         (rsp_x_out == $past(req_x_in, LATENCY)) && (rsp_y_out == $past(req_y_in, LATENCY)))
      else $error("unlimited response differs from request");

   // A zero limit scales every limited vector to the origin
   a_zero_limit: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_was_limited && (lim_ff == '0)) |->
         (rsp_x_out == '0) && (rsp_y_out == '0))
      else $error("zero limit left a nonzero component");

   // A rescaled component never takes the most negative code
   a_no_min_code: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_was_limited) |->
         ($unsigned(rsp_x_out) != {1'b1, {(DATA_WIDTH-1){1'b0}}}) &&
         ($unsigned(rsp_y_out) != {1'b1, {(DATA_WIDTH-1){1'b0}}}))
      else $error("rescaled component reached the most negative code");
`endif

endmodule

[src/vml_isqrt.sv]
module vml_isqrt
   import vml_pkg::*;
#(
   parameter int unsigned RES_WIDTH = 16,
   parameter int unsigned TAG_WIDTH = 1
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   input  logic [2*RES_WIDTH-1:0]   in_radicand,
   input  logic [TAG_WIDTH-1:0]     in_tag,
   output logic                     out_valid,
   output logic [RES_WIDTH-1:0]     out_root,
   output logic [TAG_WIDTH-1:0]     out_tag
);

   localparam int unsigned RAD_W = 2 * RES_WIDTH;
   localparam int unsigned REM_W = RES_WIDTH + 2;

   // One root bit per stage, most significant first
   logic                 valid_ff [RES_WIDTH];
   logic [RAD_W-1:0]     rad_ff   [RES_WIDTH];
   logic [REM_W-1:0]     rem_ff   [RES_WIDTH];
   logic [RES_WIDTH-1:0] root_ff  [RES_WIDTH];
   logic [TAG_WIDTH-1:0] tag_ff   [RES_WIDTH];

   genvar k;
   for (k = 0; k < RES_WIDTH; k++) begin : g_step
      logic                 valid_prev;
      logic [RAD_W-1:0]     rad_prev;
      logic [REM_W-1:0]     rem_prev;
      logic [RES_WIDTH-1:0] root_prev;
      logic [TAG_WIDTH-1:0] tag_prev;
      logic [REM_W-1:0]     rem_cat;
      logic [REM_W-1:0]     trial;
      logic                 fits;
      logic [REM_W-1:0]     rem_in;
      logic [RES_WIDTH-1:0] root_in;

      if (k == 0) begin : g_first
         assign valid_prev = in_valid;
         assign rad_prev   = in_radicand;
         assign rem_prev   = '0;
         assign root_prev  = '0;
         assign tag_prev   = in_tag;
      end else begin : g_next
         assign valid_prev = valid_ff[k-1];
         assign rad_prev   = rad_ff[k-1];
         assign rem_prev   = rem_ff[k-1];
         assign root_prev  = root_ff[k-1];
         assign tag_prev   = tag_ff[k-1];
      end

      // Bring down the next two radicand bits and try root*4+1
      assign rem_cat = {rem_prev[RES_WIDTH-1:0], rad_prev[RAD_W-1-2*k -: 2]};
      assign trial   = {root_prev, 2'b01};
      assign fits    = (rem_cat >= trial);
      assign rem_in  = fits ? (rem_cat - trial) : rem_cat;
      assign root_in = {root_prev[RES_WIDTH-2:0], fits};

      // Advance the valid bit
      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else begin
            valid_ff[k] <= valid_prev;
         end
      end

      // Advance the payload
      always_ff @(posedge clock) begin
         rad_ff[k]  <= rad_prev;
         rem_ff[k]  <= rem_in;
         root_ff[k] <= root_in;
         tag_ff[k]  <= tag_prev;
      end
   end

   assign out_valid = valid_ff[RES_WIDTH-1];
   assign out_root  = root_ff[RES_WIDTH-1];
   assign out_tag   = tag_ff[RES_WIDTH-1];

endmodule

[src/vml_div.sv]
module vml_div
   import vml_pkg::*;
#(
   parameter int unsigned QUO_WIDTH = 16,
   parameter int unsigned TAG_WIDTH = 1
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   input  logic [2*QUO_WIDTH-1:0]   in_dividend_a,
   input  logic [2*QUO_WIDTH-1:0]   in_dividend_b,
   input  logic [QUO_WIDTH-1:0]     in_divisor,
   input  logic [TAG_WIDTH-1:0]     in_tag,
   output logic                     out_valid,
   output logic [QUO_WIDTH-1:0]     out_quot_a,
   output logic [QUO_WIDTH-1:0]     out_quot_b,
   output logic [TAG_WIDTH-1:0]     out_tag
);

   // Two restoring division lanes sharing one divisor, one quotient bit per stage.
   // The quotient fits QUO_WIDTH bits only when dividend < divisor * 2^QUO_WIDTH;
   // other requests give don't-care quotients.
   logic                 valid_ff [QUO_WIDTH];
   logic [QUO_WIDTH-1:0] dvs_ff   [QUO_WIDTH];
   logic [TAG_WIDTH-1:0] tag_ff   [QUO_WIDTH];
   logic [QUO_WIDTH-1:0] low_ff   [QUO_WIDTH][2];
   logic [QUO_WIDTH-1:0] rem_ff   [QUO_WIDTH][2];
   logic [QUO_WIDTH-1:0] quot_ff  [QUO_WIDTH][2];

   logic [2*QUO_WIDTH-1:0] dividend [2];

   assign dividend[0] = in_dividend_a;
   assign dividend[1] = in_dividend_b;

   genvar k, j;
   for (k = 0; k < QUO_WIDTH; k++) begin : g_step
      logic                 valid_prev;
      logic [QUO_WIDTH-1:0] dvs_prev;
      logic [TAG_WIDTH-1:0] tag_prev;

      if (k == 0) begin : g_first
         assign valid_prev = in_valid;
         assign dvs_prev   = in_divisor;
         assign tag_prev   = in_tag;
      end else begin : g_next
         assign valid_prev = valid_ff[k-1];
         assign dvs_prev   = dvs_ff[k-1];
         assign tag_prev   = tag_ff[k-1];
      end

      // Advance the valid bit
      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else begin
            valid_ff[k] <= valid_prev;
         end
      end

      always_ff @(posedge clock) begin
         dvs_ff[k] <= dvs_prev;
         tag_ff[k] <= tag_prev;
      end

      for (j = 0; j < 2; j++) begin : g_lane
         logic [QUO_WIDTH-1:0] low_prev;
         logic [QUO_WIDTH-1:0] rem_prev;
         logic [QUO_WIDTH-1:0] quot_prev;
         logic [QUO_WIDTH:0]   rem_cat;
         logic                 fits;
         logic [QUO_WIDTH:0]   rem_diff;
         logic [QUO_WIDTH-1:0] rem_in;
         logic [QUO_WIDTH-1:0] quot_in;

         if (k == 0) begin : g_first
            assign low_prev  = dividend[j][QUO_WIDTH-1:0];
            assign rem_prev  = dividend[j][2*QUO_WIDTH-1:QUO_WIDTH];
            assign quot_prev = '0;
         end else begin : g_next
            assign low_prev  = low_ff[k-1][j];
            assign rem_prev  = rem_ff[k-1][j];
            assign quot_prev = quot_ff[k-1][j];
         end

         // Shift in the next dividend bit and subtract the divisor if it fits
         assign rem_cat  = {rem_prev, low_prev[QUO_WIDTH-1-k]};
         assign fits     = (rem_cat >= {1'b0, dvs_prev});
         assign rem_diff = rem_cat - {1'b0, dvs_prev};
         assign rem_in   = fits ? rem_diff[QUO_WIDTH-1:0] : rem_cat[QUO_WIDTH-1:0];
         assign quot_in  = {quot_prev[QUO_WIDTH-2:0], fits};

         always_ff @(posedge clock) begin
            low_ff[k][j]  <= low_prev;
            rem_ff[k][j]  <= rem_in;
            quot_ff[k][j] <= quot_in;
         end
      end
   end

   assign out_valid  = valid_ff[QUO_WIDTH-1];
   assign out_quot_a = quot_ff[QUO_WIDTH-1][0];
   assign out_quot_b = quot_ff[QUO_WIDTH-1][1];
   assign out_tag    = tag_ff[QUO_WIDTH-1];

endmodule

[sim/tb_vector_magnitude_limiter.sv]
module tb_vector_magnitude_limiter
   import vml_pkg::*;
;

   localparam int unsigned W           = 16;
   localparam int unsigned LATENCY     = 2*W + 5;
   localparam int unsigned CYCLE_LIMIT = 200000;
   localparam int unsigned MAX_ABS     = 1 << (W-1);
   localparam int unsigned MAX_REACH   = 46340;  // largest length a 16-bit vector reaches

   typedef struct packed {
      logic signed [W-1:0] x;
      logic signed [W-1:0] y;
      logic                limited;
   } limited_vector_type;

   logic                clock             = 1'b0;
   logic                reset             = 1'b1;
   logic                start             = 1'b0;
   logic                busy;
   logic signed [W-1:0] req_x_in          = '0;
   logic signed [W-1:0] req_y_in          = '0;
   logic                rsp_valid;
   logic signed [W-1:0] rsp_x_out;
   logic signed [W-1:0] rsp_y_out;
   logic                rsp_was_limited;
   logic                csr_valid         = 1'b0;
   logic                csr_ready;
   logic        [W-1:0] csr_max_magnitude = '0;

   logic [W-1:0]       limit_model     = W'(MAG_RESET);
   limited_vector_type pending_vectors[$];
   int unsigned        mismatch_count  = 0;
   int unsigned        cycle_count     = 0;
   bit                 gaps_on         = 1'b1;

   vector_magnitude_limiter #(
      .DATA_WIDTH (W)
   ) i_dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_x_in          (req_x_in),
      .req_y_in          (req_y_in),
      .rsp_valid         (rsp_valid),
      .rsp_x_out         (rsp_x_out),
      .rsp_y_out         (rsp_y_out),
      .rsp_was_limited   (rsp_was_limited),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_max_magnitude (csr_max_magnitude)
   );

   always #5 clock = ~clock;

   // Floor square root, one result bit per step from the top
   function automatic logic [W-1:0] floor_sqrt(input logic [2*W:0] sum);
      logic [W-1:0]   root;
      logic [W-1:0]   trial;
      logic [2*W+1:0] square;
      root = '0;
      for (int b = W-1; b >= 0; b--) begin
         trial  = root | (W'(1) << b);
         square = trial * trial;
         if (square <= {1'b0, sum}) begin
            root = trial;
         end
      end
      return root;
   endfunction

   // Expected output of one request under the given limit
   function automatic limited_vector_type limit_vector(input logic signed [W-1:0] x,
                                                       input logic signed [W-1:0] y,
                                                       input logic        [W-1:0] lim);
      limited_vector_type r;
      logic [W-1:0]       ax;
      logic [W-1:0]       ay;
      logic [2*W:0]       sum;
      logic [W-1:0]       mag;
      logic [2*W-1:0]     qx;
      logic [2*W-1:0]     qy;
      ax  = x[W-1] ? (~x + 1'b1) : x;
      ay  = y[W-1] ? (~y + 1'b1) : y;
      sum = ax * ax + ay * ay;
      mag = floor_sqrt(sum);
      if (mag > lim) begin
         // scale magnitudes, truncate, then restore the signs
         qx        = (ax * lim) / mag;
         qy        = (ay * lim) / mag;
         r.x       = x[W-1] ? (~qx[W-1:0] + 1'b1) : qx[W-1:0];
         r.y       = y[W-1] ? (~qy[W-1:0] + 1'b1) : qy[W-1:0];
         r.limited = 1'b1;
      end else begin
         r.x       = x;
         r.y       = y;
         r.limited = 1'b0;
      end
      return r;
   endfunction

   // Issue one request after a random gap when gaps are on, record its expected output
   task automatic send_vector(input logic signed [W-1:0] x, input logic signed [W-1:0] y);
      while (gaps_on && $urandom_range(0, 99) < 27) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start    <= 1'b1;
      req_x_in <= x;
      req_y_in <= y;
      @(posedge clock);
      while (busy) @(posedge clock);
      pending_vectors.push_back(limit_vector(x, y, limit_model));
   endtask

   // Drop start and wait for every outstanding request to come back
   task automatic drain_results();
      start <= 1'b0;
      @(posedge clock);
      while (pending_vectors.size() != 0) @(posedge clock);
   endtask

   // Write the limit register; call only while the pipeline is empty
   task automatic write_limit(input logic [W-1:0] value);
      csr_valid         <= 1'b1;
      csr_max_magnitude <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid   <= 1'b0;
      limit_model  = value;
   endtask

   // Compare each output with the oldest pending request
   always @(posedge clock) begin : check_results
      limited_vector_type want;
      if (!reset && rsp_valid) begin
         if (pending_vectors.size() == 0) begin
            $display("%0t: output with no pending request: x=%0d y=%0d limited=%0b",
                     $time, rsp_x_out, rsp_y_out, rsp_was_limited);
            mismatch_count++;
         end else begin
            want = pending_vectors.pop_front();
            if (rsp_x_out !== want.x) begin
               $display("%0t: x_out mismatch: expected %0d, actual %0d",
                        $time, want.x, rsp_x_out);
               mismatch_count++;
            end
            if (rsp_y_out !== want.y) begin
               $display("%0t: y_out mismatch: expected %0d, actual %0d",
                        $time, want.y, rsp_y_out);
               mismatch_count++;
            end
            if (rsp_was_limited !== want.limited) begin
               $display("%0t: was_limited mismatch: expected %0b, actual %0b",
                        $time, want.limited, rsp_was_limited);
               mismatch_count++;
            end
         end
      end
   end

   // Extremes under the limit left by reset, most negative component included
   task automatic test_reset_limit();
      send_vector(16'sd0, 16'sd0);
      send_vector(16'sd32767, 16'sd0);
      send_vector(-16'sd32768, 16'sd0);
      send_vector(16'sd0, -16'sd32768);
      send_vector(-16'sd32768, -16'sd32768);
      send_vector(16'sd32767, 16'sd32767);
      send_vector(16'sd23170, 16'sd23170);
      send_vector(-16'sd23170, 16'sd23171);
      send_vector(16'sd1, -16'sd1);
   endtask

   // Limit of zero: every nonzero vector collapses to the origin
   task automatic test_zero_limit();
      drain_results();
      write_limit('0);
      send_vector(16'sd0, 16'sd0);
      send_vector(16'sd1, 16'sd0);
      send_vector(16'sd0, -16'sd1);
      send_vector(-16'sd32768, 16'sd32767);
   endtask

   // Full-scale limit: nothing is ever limited
   task automatic test_full_limit();
      drain_results();
      write_limit('1);
      send_vector(-16'sd32768, -16'sd32768);
      send_vector(16'sd32767, -16'sd32768);
   endtask

   // Lengths at and just above the limit, some that the floor root keeps unlimited
   task automatic test_root_rounding();
      drain_results();
      write_limit(W'(5));
      send_vector(16'sd3, 16'sd4);
      send_vector(-16'sd4, -16'sd4);
      send_vector(16'sd4, 16'sd5);
      send_vector(-16'sd5, -16'sd1);
      send_vector(16'sd6, 16'sd0);
      drain_results();
      write_limit(W'(1));
      send_vector(16'sd1, 16'sd1);
      send_vector(-16'sd1, 16'sd1);
      send_vector(16'sd2, 16'sd0);
   endtask

   // Random vectors, some of them aimed at the current limit
   task automatic send_random_vectors(input int unsigned count);
      logic signed [W-1:0] x;
      logic signed [W-1:0] y;
      logic signed [W-1:0] swap;
      logic signed [W-1:0] corners[5];
      int unsigned         pick;
      int unsigned         target;
      int unsigned         ax;
      int unsigned         ay;
      corners = '{-16'sd32768, -16'sd1, 16'sd0, 16'sd1, 16'sd32767};
      repeat (count) begin
         pick = $urandom_range(0, 99);
         if (pick < 35) begin
            x = W'($urandom);
            y = W'($urandom);
         end else if (pick < 55) begin
            x = W'($urandom_range(0, 64) - 32);
            y = W'($urandom_range(0, 64) - 32);
         end else if (pick < 90) begin
            // land the length on the limit or one step either side
            target = limit_model + $urandom_range(0, 2);
            if (target > 0) target--;
            if (target > MAX_REACH) target = MAX_REACH - $urandom_range(0, 2);
            ax = $urandom_range(0, (target < MAX_ABS) ? target : MAX_ABS);
            ay = 32'(floor_sqrt((2*W+1)'(target * target - ax * ax)));
            if (ay > MAX_ABS) ay = MAX_ABS;
            x = ($urandom_range(0, 1) || ax == MAX_ABS) ? W'(-ax) : W'(ax);
            y = ($urandom_range(0, 1) || ay == MAX_ABS) ? W'(-ay) : W'(ay);
            if ($urandom_range(0, 1)) begin
               swap = x;
               x    = y;
               y    = swap;
            end
         end else begin
            x = corners[$urandom_range(0, 4)];
            y = corners[$urandom_range(0, 4)];
         end
         send_vector(x, y);
      end
   endtask

   // Random phases over several limits, one stretch without gaps
   task automatic test_random_limits();
      drain_results();
      write_limit(W'($urandom));
      send_random_vectors(90);
      drain_results();
      write_limit('0);
      send_random_vectors(40);
      drain_results();
      write_limit('1);
      send_random_vectors(40);
      drain_results();
      write_limit(W'($urandom_range(0, 300)));
      send_random_vectors(90);
      drain_results();
      write_limit(W'($urandom_range(16000, 40000)));
      gaps_on = 1'b0;
      send_random_vectors(100);
      gaps_on = 1'b1;
      drain_results();
      write_limit(W'($urandom));
      send_random_vectors(90);
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_reset_limit();
      test_zero_limit();
      test_full_limit();
      test_root_rounding();
      test_random_limits();
      drain_results();
      repeat (LATENCY + 10) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   // End a hung run
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("FAIL");
      $finish;
   end

endmodule

[filelist.f]
src/vml_pkg.sv
src/vml_isqrt.sv
src/vml_div.sv
src/vector_magnitude_limiter.sv
sim/tb_vector_magnitude_limiter.sv
